// ----- rtl/wsq_pkg.sv -----
// ----------------------------------------------------------------------------
// wsq_pkg
// Shared types, sizes and codes for the per-core work-stealing queue set.
// ----------------------------------------------------------------------------
package wsq_pkg;

  localparam int CORES       = 8;
  localparam int SLOT_SHIFT  = 4;
  localparam int HANDLE_BITS = 32;

  localparam int NSLOT  = 1 << SLOT_SHIFT;
  localparam int IDX_W  = SLOT_SHIFT + 1;
  localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int ADDR_W = CORE_W + SLOT_SHIFT;
  localparam int DEPTH  = CORES * NSLOT;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic       OP_PUSH   = 1'b0;
  localparam logic       OP_TAKE   = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOWORK = 2'd2;

  typedef struct packed {
    logic        op;
    logic [2:0]  core;
    logic [31:0] handle;
    logic [2:0]  start_offset;
  } wsq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [2:0]  source_core;
    logic        was_stolen;
  } wsq_out_t;

  // one classified operation for the back end
  typedef struct packed {
    logic                   wr;
    logic                   rd;
    logic [ADDR_W-1:0]      addr;
    logic [HANDLE_BITS-1:0] wdata;
    logic [1:0]             status;
    logic [2:0]             source_core;
    logic                   was_stolen;
  } wsq_cmd_t;

  typedef logic [7:0][CORE_W-1:0] start_tbl_t;

  // start_offset modulo CORES for every 3-bit offset, built at elaboration
  function automatic start_tbl_t build_start_tbl();
    start_tbl_t t;
    for (int i = 0; i < 8; i++) begin
      t[i] = CORE_W'(i % CORES);
    end
    return t;
  endfunction

  localparam start_tbl_t START_TBL = build_start_tbl();

endpackage

// ----- rtl/wsq_front.sv -----
// ----------------------------------------------------------------------------
// wsq_front
// Accepts requests, owns the head/tail indexes and the steal enable, picks
// the victim deque and hands a classified command to the back end.
// ----------------------------------------------------------------------------
module wsq_front import wsq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  wsq_in_t  in_item,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output wsq_cmd_t cmd
);

  logic [IDX_W-1:0] head_r [CORES];
  logic [IDX_W-1:0] tail_r [CORES];
  logic [IDX_W-1:0] head_nxt [CORES];
  logic [IDX_W-1:0] tail_nxt [CORES];
  logic             steal_en_r;

  logic [CORE_W-1:0] cidx;
  logic              in_range;
  logic [IDX_W-1:0]  own_h;
  logic [IDX_W-1:0]  own_t;
  logic [IDX_W-1:0]  own_hm1;
  logic              own_full;
  logic [CORE_W-1:0] k;
  logic [CORES-1:0]  cand;
  logic [CORES-1:0]  cand_hi;
  logic              victim_found;
  logic [CORE_W-1:0] victim;
  logic [IDX_W-1:0]  vict_t;

  function automatic logic [CORE_W-1:0] lowest_set(input logic [CORES-1:0] v);
    logic [CORE_W-1:0] idx;
    idx = '0;
    for (int c = CORES - 1; c >= 0; c--) begin
      if (v[c]) idx = CORE_W'(c);
    end
    return idx;
  endfunction

  assign in_range = (int'(in_item.core) < CORES);
  assign cidx     = CORE_W'(in_item.core);
  assign own_h    = head_r[cidx];
  assign own_t    = tail_r[cidx];
  assign own_hm1  = own_h - IDX_W'(1);
  assign own_full = ((own_h - own_t) == IDX_W'(NSLOT));
  assign k        = START_TBL[in_item.start_offset];

  // nonempty deques other than the requester; the scan wraps at k
  always_comb begin
    for (int c = 0; c < CORES; c++) begin
      cand[c]    = (head_r[c] != tail_r[c]) && (CORE_W'(c) != cidx);
      cand_hi[c] = cand[c] && (CORE_W'(c) >= k);
    end
  end

  assign victim_found = |cand;
  assign victim       = (|cand_hi) ? lowest_set(cand_hi) : lowest_set(cand);
  assign vict_t       = tail_r[victim];

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cmd             = '0;
    cmd.status      = ST_NOWORK;
    if (in_item.op == OP_PUSH) begin
      cmd.source_core = in_item.core;
      if (!in_range || own_full) begin
        cmd.status = ST_FULL;
      end else begin
        cmd.status     = ST_OK;
        cmd.wr         = 1'b1;
        cmd.addr       = {cidx, own_h[SLOT_SHIFT-1:0]};
        cmd.wdata      = HANDLE_BITS'(in_item.handle);
        head_nxt[cidx] = own_h + IDX_W'(1);
      end
    end else if (in_range) begin
      if (own_h != own_t) begin
        cmd.status      = ST_OK;
        cmd.rd          = 1'b1;
        cmd.addr        = {cidx, own_hm1[SLOT_SHIFT-1:0]};
        cmd.source_core = in_item.core;
        head_nxt[cidx]  = own_hm1;
      end else if (steal_en_r && victim_found) begin
        cmd.status       = ST_OK;
        cmd.rd           = 1'b1;
        cmd.addr         = {victim, vict_t[SLOT_SHIFT-1:0]};
        cmd.source_core  = 3'(victim);
        cmd.was_stolen   = 1'b1;
        tail_nxt[victim] = vict_t + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CORES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
      end
    end else if (acc) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steal_en_r <= 1'b1;
    end else if (cfg_we) begin
      steal_en_r <= cfg_wdata;
    end
  end

endmodule

// ----- rtl/wsq_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// wsq_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module wsq_cmd_fifo import wsq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  wsq_cmd_t din,
  input  logic     pop,
  output wsq_cmd_t dout,
  output logic     full,
  output logic     empty
);

  wsq_cmd_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/wsq_back.sv -----
// ----------------------------------------------------------------------------
// wsq_back
// Executes queued commands against the slot memory and drives the result
// strobe in the cycle after each command.
// ----------------------------------------------------------------------------
module wsq_back import wsq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  wsq_cmd_t cmd,
  output logic     out_valid,
  output wsq_out_t out_item
);

  logic [HANDLE_BITS-1:0] slot_mem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_data_r;
  logic                   valid_r;
  logic                   rd_r;
  logic [1:0]             status_r;
  logic [2:0]             source_r;
  logic                   stolen_r;

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd.wr) begin
      slot_mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd_valid && cmd.rd) begin
      rd_data_r <= slot_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      rd_r     <= cmd.rd;
      status_r <= cmd.status;
      source_r <= cmd.source_core;
      stolen_r <= cmd.was_stolen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd_valid;
    end
  end

  assign out_valid            = valid_r;
  assign out_item.status      = status_r;
  assign out_item.out_handle  = rd_r ? 32'(rd_data_r) : 32'd0;
  assign out_item.source_core = source_r;
  assign out_item.was_stolen  = stolen_r;

endmodule

// ----- rtl/work_stealing_queue_set.sv -----
// ----------------------------------------------------------------------------
// work_stealing_queue_set
// One ring deque of work handles per core, with push, LIFO pop and
// rotated-priority stealing from other cores' tails.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive in_item and raise start; the transaction is taken at a
//   clock edge with start high and busy low. op selects push or take.
//   Result: exactly one per request, shown on out_item for one cycle with
//   out_valid high. The receiver cannot stall; results are never held.
//   Flow: the front classifies a request, updates the indexes and writes
//   the command into the queue at the accept edge; the back end then does
//   the slot memory access from the queue head and registers the result
//   with out_valid.
//   Throughput: one request per cycle; the back end drains each command the
//   cycle after it is queued, so the queue never holds more than one entry
//   and busy never rises.
//   Configuration: cfg_we/cfg_wdata write steal_enable; write while idle.
//   Reset: all deques empty, steal_enable set; slot memory is not cleared
//   (the head/tail discipline never reads an unwritten slot).
// ----------------------------------------------------------------------------
module work_stealing_queue_set import wsq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  wsq_in_t  in_item,
  output logic     out_valid,
  output wsq_out_t out_item,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic     acc;
  wsq_cmd_t front_cmd;
  wsq_cmd_t q_cmd;
  logic     q_full;
  logic     q_empty;

  assign acc  = start && !busy;
  assign busy = q_full;

  wsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (front_cmd)
  );

  wsq_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (acc),
    .din   (front_cmd),
    .pop   (!q_empty),
    .dout  (q_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  wsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // a stolen handle always comes with a success status
  a_stolen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.was_stolen) |-> (out_item.status == ST_OK))
    else $error("stolen result without success status");

  // no-work results carry zeros
  a_nowork_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_NOWORK) |->
      (out_item.out_handle == 32'd0 && out_item.source_core == 3'd0 &&
       !out_item.was_stolen))
    else $error("no-work result with nonzero fields");

  // a queued command reaches the result port on the next cycle
  a_cmd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |=> out_valid)
    else $error("queued command produced no result");

endmodule

// ----- bench/tb_work_stealing_queue_set.sv -----
// ----------------------------------------------------------------------------
// tb_work_stealing_queue_set
// Self-checking bench for the per-core work-stealing queue set. A local
// model of the deques predicts every push/take transaction on acceptance;
// a monitor compares each strobed result against the oldest prediction.
// Directed cases cover field extremes, own pop, full deque, stealing on
// and off; random phases then mix pushes and takes with random idling.
// ----------------------------------------------------------------------------
module tb_work_stealing_queue_set import wsq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  wsq_in_t  in_item;
  logic     out_valid;
  wsq_out_t out_item;
  logic     cfg_we;
  logic     cfg_wdata;

  // local copy of the deque state
  logic [HANDLE_BITS-1:0] dq_slots [CORES][NSLOT];
  logic [IDX_W-1:0]       dq_head  [CORES];
  logic [IDX_W-1:0]       dq_tail  [CORES];
  logic                   steal_en;

  wsq_out_t pending_results[$];
  int       errors;
  int       cycles = 0;
  bit       burst_mode;

  work_stealing_queue_set dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Applies one transaction to the local deques and returns its result.
  function automatic wsq_out_t apply_request(wsq_in_t req);
    wsq_out_t         r;
    logic [IDX_W-1:0] h;
    logic [IDX_W-1:0] t;
    logic [IDX_W-1:0] fill;
    int               i;
    int               j;
    r = '0;
    h = dq_head[req.core];
    t = dq_tail[req.core];
    if (req.op == OP_PUSH) begin
      r.source_core = req.core;
      fill = h - t;
      if (fill == IDX_W'(NSLOT)) begin
        r.status = ST_FULL;
      end else begin
        dq_slots[req.core][h[SLOT_SHIFT-1:0]] = req.handle;
        dq_head[req.core] = h + 1'b1;
        r.status = ST_OK;
      end
      return r;
    end
    if (h != t) begin
      h = h - 1'b1;
      dq_head[req.core] = h;
      r.status      = ST_OK;
      r.out_handle  = dq_slots[req.core][h[SLOT_SHIFT-1:0]];
      r.source_core = req.core;
      return r;
    end
    if (steal_en) begin
      for (i = 0; i < CORES; i++) begin
        j = (i + int'(req.start_offset)) % CORES;
        if (j != int'(req.core) && dq_head[j] != dq_tail[j]) begin
          t = dq_tail[j];
          dq_tail[j] = t + 1'b1;
          r.status      = ST_OK;
          r.out_handle  = dq_slots[j][t[SLOT_SHIFT-1:0]];
          r.source_core = 3'(j);
          r.was_stolen  = 1'b1;
          return r;
        end
      end
    end
    r.status = ST_NOWORK;
    return r;
  endfunction

  // result monitor: the receiver cannot stall, so every strobe is a transaction
  always @(posedge clk) begin
    wsq_out_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_r.status, out_item.status);
        end
        if (out_item.out_handle !== exp_r.out_handle) begin
          errors++;
          $display("%0t: out_handle expected %h actual %h",
                   $time, exp_r.out_handle, out_item.out_handle);
        end
        if (out_item.source_core !== exp_r.source_core) begin
          errors++;
          $display("%0t: source_core expected %0d actual %0d",
                   $time, exp_r.source_core, out_item.source_core);
        end
        if (out_item.was_stolen !== exp_r.was_stolen) begin
          errors++;
          $display("%0t: was_stolen expected %0d actual %0d",
                   $time, exp_r.was_stolen, out_item.was_stolen);
        end
      end
    end
  end

  // Leaves start high on return so back-to-back transactions need no toggle.
  task automatic issue_request(wsq_in_t req);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(req));
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_steal_enable(logic v);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    steal_en = v;
  endtask

  function automatic wsq_in_t make_request(logic op, int core, logic [31:0] handle,
                                           int offset);
    wsq_in_t req;
    req.op           = op;
    req.core         = 3'(core);
    req.handle       = handle;
    req.start_offset = 3'(offset);
    return req;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // extreme handles and cores, own pop, steal wrapping past the requester
  task automatic test_lifo_extremes();
    issue_request(make_request(OP_PUSH, 0, 32'h0000_0000, 0));
    issue_request(make_request(OP_PUSH, 7, 32'hFFFF_FFFF, 7));
    issue_request(make_request(OP_TAKE, 7, 32'hFFFF_FFFF, 0));
    issue_request(make_request(OP_TAKE, 7, 32'h0, 7));
    issue_request(make_request(OP_TAKE, 3, 32'h1234_5678, 5));
  endtask

  task automatic test_full_deque();
    for (int i = 0; i < NSLOT; i++) begin
      issue_request(make_request(OP_PUSH, 5, $urandom, $urandom_range(0, 7)));
      idle_gap(i % 3);
    end
    issue_request(make_request(OP_PUSH, 5, 32'hDEAD_BEEF, 0));
  endtask

  task automatic test_steal_disable();
    write_steal_enable(1'b0);
    issue_request(make_request(OP_TAKE, 1, 32'h0, 5));
    write_steal_enable(1'b1);
    issue_request(make_request(OP_TAKE, 1, 32'h0, 6));
    issue_request(make_request(OP_TAKE, 5, 32'h0, 2));
  endtask

  // push_pct biases toward filling or draining; span < CORES concentrates
  // traffic on a few cores so deques reach full
  task automatic test_random_traffic(int count, int push_pct, int span);
    int      base;
    wsq_in_t req;
    base = $urandom_range(0, CORES - 1);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) base = $urandom_range(0, CORES - 1);
      if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
      req = make_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TAKE,
                         (base + $urandom_range(0, span - 1)) % CORES,
                         $urandom, $urandom_range(0, 7));
      issue_request(req);
      if ($urandom_range(0, 59) == 0) wait_results_drained();
      else idle_gap(pick_gap());
    end
  endtask

  initial begin
    start      <= 1'b0;
    in_item    <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 1'b0;
    rst_n      <= 1'b0;
    errors     = 0;
    burst_mode = 1'b0;
    steal_en   = 1'b1;
    for (int c = 0; c < CORES; c++) begin
      dq_head[c] = '0;
      dq_tail[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lifo_extremes();
    test_full_deque();
    test_steal_disable();
    test_random_traffic(400, 55, CORES);
    test_random_traffic(300, 70, 2);
    write_steal_enable(1'b0);
    test_random_traffic(200, 50, CORES);
    write_steal_enable(1'b1);
    test_random_traffic(400, 35, CORES);

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/wsq_pkg.sv
rtl/wsq_front.sv
rtl/wsq_cmd_fifo.sv
rtl/wsq_back.sv
rtl/work_stealing_queue_set.sv
bench/tb_work_stealing_queue_set.sv
